// ===== design/ubxpvt_pkg.sv =====
package ubxpvt_pkg;

    localparam logic [7:0] SYNC_FIRST     = 8'hB5;
    localparam logic [7:0] SYNC_SECOND    = 8'h62;
    localparam logic [7:0] PVT_CLASS      = 8'h01;
    localparam logic [7:0] PVT_ID         = 8'h07;
    localparam logic [15:0] PVT_LENGTH    = 16'd92;
    localparam logic [7:0] DATE_TIME_BITS = 8'h03;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    // frame header positions, counted from the first sync byte
    localparam int unsigned POS_SYNC_FIRST  = 0;
    localparam int unsigned POS_SYNC_SECOND = 1;
    localparam int unsigned POS_CLASS       = 2;
    localparam int unsigned POS_ID          = 3;
    localparam int unsigned POS_LEN_LO      = 4;
    localparam int unsigned POS_LEN_HI      = 5;
    localparam int unsigned POS_PAYLOAD     = 6;
    localparam int unsigned FRAME_OVERHEAD  = 8;

    // payload offsets inside NAV-PVT
    localparam int unsigned OFF_YEAR_LO  = 4;
    localparam int unsigned OFF_YEAR_HI  = 5;
    localparam int unsigned OFF_MONTH    = 6;
    localparam int unsigned OFF_DAY      = 7;
    localparam int unsigned OFF_HOUR     = 8;
    localparam int unsigned OFF_MINUTE   = 9;
    localparam int unsigned OFF_SECOND   = 10;
    localparam int unsigned OFF_VALID    = 11;
    localparam int unsigned OFF_NANO_LO  = 16;
    localparam int unsigned OFF_NANO_HI  = 19;
    localparam int unsigned OFF_FIX      = 20;
    localparam int unsigned OFF_NUM_SV   = 23;
    localparam int unsigned OFF_LON_LO   = 24;
    localparam int unsigned OFF_LON_HI   = 27;
    localparam int unsigned OFF_LAT_LO   = 28;
    localparam int unsigned OFF_LAT_HI   = 31;
    localparam int unsigned OFF_HGT_LO   = 32;
    localparam int unsigned OFF_HGT_HI   = 35;
    localparam int unsigned OFF_SPEED_LO = 60;
    localparam int unsigned OFF_SPEED_HI = 63;

endpackage

// ===== design/ubx_frame_parser_nav_pvt_top.sv =====
// NAV-PVT frame parser. Each input transfer is either one received byte
// (action 0) or one millisecond tick (action 1), and each one produces exactly
// one output transfer, offered the cycle after the input: a new input is accepted
// every cycle while the output side keeps up. The parser hunts the 0xB5 0x62
// sync pair, reads class, id and length, drops frames whose total size exceeds
// FRAME_CAPACITY, and checks the 8-bit Fletcher sum. A good NAV-PVT frame updates
// the held position, fix, satellites, nanoseconds and ground speed (negative
// speed reads as zero) and raises frame_accepted on the result of its last check
// byte; the UTC date and time update only when both validDate and validTime are
// set, flagged by time_updated. receiver_active drops once more ticks than
// timeout_ticks pass without an accepted frame; the idle count saturates, so a
// timeout of 65535 never expires. The timeout register (reset 3000) is written
// via the cfg channel; users must do so only while the parser is idle, unchecked.
module ubx_frame_parser_nav_pvt_top #(
    parameter int unsigned FRAME_CAPACITY = 128
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        timeout_ticks,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         rx_byte,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               frame_accepted,
    output logic               time_updated,
    output logic [55:0]        utc_date_time,
    output logic signed [31:0] sub_second_ns,
    output logic [7:0]         fix_type,
    output logic [7:0]         satellites,
    output logic signed [31:0] longitude,
    output logic signed [31:0] latitude,
    output logic signed [31:0] height_mm,
    output logic [30:0]        ground_speed,
    output logic               receiver_active
);

    localparam int unsigned PW = $clog2(FRAME_CAPACITY);

    logic [PW-1:0]  pos_reg, pos_next;
    logic [7:0]     sum_a_reg, sum_a_next;
    logic [7:0]     sum_b_reg, sum_b_next;
    logic [7:0]     class_reg;
    logic [7:0]     id_reg;
    logic [15:0]    len_reg;
    logic [7:0]     chk_a_reg;

    logic [7:0]     stg_valid_reg;
    logic [55:0]    stg_dt_reg;
    logic [31:0]    stg_nano_reg;
    logic [31:0]    stg_lon_reg;
    logic [31:0]    stg_lat_reg;
    logic [31:0]    stg_hgt_reg;
    logic [31:0]    stg_speed_reg;
    logic [7:0]     stg_fix_reg;
    logic [7:0]     stg_sats_reg;

    logic [55:0]    held_dt_reg;
    logic [31:0]    held_nano_reg;
    logic [31:0]    held_lon_reg;
    logic [31:0]    held_lat_reg;
    logic [31:0]    held_hgt_reg;
    logic [30:0]    held_speed_reg;
    logic [7:0]     held_fix_reg;
    logic [7:0]     held_sats_reg;

    logic           active_reg, active_next;
    logic [15:0]    idle_reg, idle_next;
    logic [15:0]    timeout_reg;

    logic           out_valid_reg;
    logic           accepted_reg;
    logic           time_reg;

    logic           take;
    logic           take_byte;
    logic [PW-1:0]  off;
    logic [15:0]    off_ext;
    logic           in_payload;
    logic           payload_byte;
    logic [7:0]     sum_a_add;
    logic [7:0]     sum_b_add;
    logic [16:0]    frame_size;
    logic           pvt_ok;
    logic           dt_ok;

    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign take      = in_valid && in_ready;
    assign take_byte = take && !action;

    assign off          = pos_reg - PW'(ubxpvt_pkg::POS_PAYLOAD);
    assign off_ext      = 16'(off);
    assign in_payload   = pos_reg >= PW'(ubxpvt_pkg::POS_PAYLOAD);
    assign payload_byte = in_payload && (off_ext < len_reg);
    assign sum_a_add    = sum_a_reg + rx_byte;
    assign sum_b_add    = sum_b_reg + sum_a_add;
    assign frame_size   = {1'b0, rx_byte, len_reg[7:0]}
                          + 17'(ubxpvt_pkg::FRAME_OVERHEAD);

    always_comb
    begin
        pos_next    = pos_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        pvt_ok      = 1'b0;
        dt_ok       = 1'b0;
        if (take_byte)
        begin
            if (pos_reg == PW'(ubxpvt_pkg::POS_SYNC_FIRST))
            begin
                if (rx_byte == ubxpvt_pkg::SYNC_FIRST)
                    pos_next = PW'(ubxpvt_pkg::POS_SYNC_SECOND);
            end
            else if (pos_reg == PW'(ubxpvt_pkg::POS_SYNC_SECOND))
            begin
                pos_next = (rx_byte == ubxpvt_pkg::SYNC_SECOND)
                           ? PW'(ubxpvt_pkg::POS_CLASS)
                           : PW'(ubxpvt_pkg::POS_SYNC_FIRST);
            end
            else if (pos_reg == PW'(ubxpvt_pkg::POS_CLASS))
            begin
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                pos_next   = PW'(ubxpvt_pkg::POS_ID);
            end
            else if (!in_payload)
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                if (pos_reg == PW'(ubxpvt_pkg::POS_LEN_HI))
                    // drop frames larger than the capacity
                    pos_next = (frame_size > 17'(FRAME_CAPACITY))
                               ? PW'(ubxpvt_pkg::POS_SYNC_FIRST)
                               : PW'(ubxpvt_pkg::POS_PAYLOAD);
                else
                    pos_next = pos_reg + PW'(1);
            end
            else if (payload_byte)
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                pos_next   = pos_reg + PW'(1);
            end
            else if (off_ext == len_reg)
            begin
                pos_next = pos_reg + PW'(1);
            end
            else
            begin
                pvt_ok   = (chk_a_reg == sum_a_reg) && (rx_byte == sum_b_reg)
                           && (class_reg == ubxpvt_pkg::PVT_CLASS)
                           && (id_reg == ubxpvt_pkg::PVT_ID)
                           && (len_reg == ubxpvt_pkg::PVT_LENGTH);
                dt_ok    = pvt_ok && ((stg_valid_reg & ubxpvt_pkg::DATE_TIME_BITS)
                                      == ubxpvt_pkg::DATE_TIME_BITS);
                pos_next = PW'(ubxpvt_pkg::POS_SYNC_FIRST);
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idle_next   = idle_reg;
        if (take)
        begin
            if (pvt_ok)
            begin
                active_next = 1'b1;
                idle_next   = '0;
            end
            else if (action && idle_reg != ubxpvt_pkg::IDLE_MAX)
            begin
                idle_next = idle_reg + 16'd1;
            end
            if (active_next && idle_next > timeout_reg)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            active_reg     <= 1'b0;
            idle_reg       <= '0;
            timeout_reg    <= ubxpvt_pkg::TIMEOUT_RESET;
            held_dt_reg    <= '0;
            held_nano_reg  <= '0;
            held_lon_reg   <= '0;
            held_lat_reg   <= '0;
            held_hgt_reg   <= '0;
            held_speed_reg <= '0;
            held_fix_reg   <= '0;
            held_sats_reg  <= '0;
            out_valid_reg  <= 1'b0;
            accepted_reg   <= 1'b0;
            time_reg       <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            active_reg <= active_next;
            idle_reg   <= idle_next;
            if (cfg_valid)
                timeout_reg <= timeout_ticks;
            if (pvt_ok)
            begin
                held_nano_reg  <= stg_nano_reg;
                held_lon_reg   <= stg_lon_reg;
                held_lat_reg   <= stg_lat_reg;
                held_hgt_reg   <= stg_hgt_reg;
                held_speed_reg <= stg_speed_reg[31] ? '0 : stg_speed_reg[30:0];
                held_fix_reg   <= stg_fix_reg;
                held_sats_reg  <= stg_sats_reg;
            end
            if (dt_ok)
                held_dt_reg <= stg_dt_reg;
            if (take)
            begin
                out_valid_reg <= 1'b1;
                accepted_reg  <= pvt_ok;
                time_reg      <= dt_ok;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            if (pos_reg == PW'(ubxpvt_pkg::POS_CLASS))
                class_reg <= rx_byte;
            if (pos_reg == PW'(ubxpvt_pkg::POS_ID))
                id_reg <= rx_byte;
            if (pos_reg == PW'(ubxpvt_pkg::POS_LEN_LO))
                len_reg <= {8'h00, rx_byte};
            if (pos_reg == PW'(ubxpvt_pkg::POS_LEN_HI))
                len_reg[15:8] <= rx_byte;
            if (in_payload && !payload_byte && off_ext == len_reg)
                chk_a_reg <= rx_byte;
            if (payload_byte)
            begin
                case (off) inside
                    PW'(ubxpvt_pkg::OFF_YEAR_LO): stg_dt_reg[47:40] <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_YEAR_HI): stg_dt_reg[55:48] <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_MONTH):   stg_dt_reg[39:32] <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_DAY):     stg_dt_reg[31:24] <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_HOUR):    stg_dt_reg[23:16] <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_MINUTE):  stg_dt_reg[15:8]  <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_SECOND):  stg_dt_reg[7:0]   <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_VALID):   stg_valid_reg     <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_FIX):     stg_fix_reg       <= rx_byte;
                    PW'(ubxpvt_pkg::OFF_NUM_SV):  stg_sats_reg      <= rx_byte;
                    [PW'(ubxpvt_pkg::OFF_NANO_LO):PW'(ubxpvt_pkg::OFF_NANO_HI)]:
                        stg_nano_reg[8*off[1:0] +: 8] <= rx_byte;
                    [PW'(ubxpvt_pkg::OFF_LON_LO):PW'(ubxpvt_pkg::OFF_LON_HI)]:
                        stg_lon_reg[8*off[1:0] +: 8] <= rx_byte;
                    [PW'(ubxpvt_pkg::OFF_LAT_LO):PW'(ubxpvt_pkg::OFF_LAT_HI)]:
                        stg_lat_reg[8*off[1:0] +: 8] <= rx_byte;
                    [PW'(ubxpvt_pkg::OFF_HGT_LO):PW'(ubxpvt_pkg::OFF_HGT_HI)]:
                        stg_hgt_reg[8*off[1:0] +: 8] <= rx_byte;
                    [PW'(ubxpvt_pkg::OFF_SPEED_LO):PW'(ubxpvt_pkg::OFF_SPEED_HI)]:
                        stg_speed_reg[8*off[1:0] +: 8] <= rx_byte;
                    default: ;
                endcase
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_accepted  = accepted_reg;
    assign time_updated    = time_reg;
    assign utc_date_time   = held_dt_reg;
    assign sub_second_ns   = held_nano_reg;
    assign fix_type        = held_fix_reg;
    assign satellites      = held_sats_reg;
    assign longitude       = held_lon_reg;
    assign latitude        = held_lat_reg;
    assign height_mm       = held_hgt_reg;
    assign ground_speed    = held_speed_reg;
    assign receiver_active = active_reg;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import ubxpvt_pkg::*;

    localparam int unsigned FRAME_CAP = 128;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic       act;
        logic [7:0] data;
    } rx_item_t;

    typedef struct {
        logic        accepted;
        logic        time_upd;
        logic [55:0] utc;
        logic [31:0] nano;
        logic [7:0]  fix;
        logic [7:0]  sats;
        logic [31:0] lon;
        logic [31:0] lat;
        logic [31:0] hgt;
        logic [30:0] speed;
        logic        active;
    } pvt_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] timeout_ticks = 16'd0;

    logic in_valid = 1'b0;
    logic in_ready;
    logic action = 1'b0;
    logic [7:0] rx_byte = 8'd0;

    logic out_valid;
    logic out_ready = 1'b0;
    logic frame_accepted;
    logic time_updated;
    logic [55:0] utc_date_time;
    logic signed [31:0] sub_second_ns;
    logic [7:0] fix_type;
    logic [7:0] satellites;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] height_mm;
    logic [30:0] ground_speed;
    logic receiver_active;

    ubx_frame_parser_nav_pvt_top #(
        .FRAME_CAPACITY(FRAME_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .timeout_ticks(timeout_ticks),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_accepted(frame_accepted),
        .time_updated(time_updated),
        .utc_date_time(utc_date_time),
        .sub_second_ns(sub_second_ns),
        .fix_type(fix_type),
        .satellites(satellites),
        .longitude(longitude),
        .latitude(latitude),
        .height_mm(height_mm),
        .ground_speed(ground_speed),
        .receiver_active(receiver_active)
    );

    always #5 clk = ~clk;

    rx_item_t rx_stream_q[$];
    pvt_report_t pvt_report_q[$];
    pvt_report_t head_rpt;
    logic [7:0] frame_body[0:127];

    int items_queued = 0;
    int items_taken = 0;
    int results_checked = 0;
    int mismatches = 0;
    int frames_ok = 0;
    int time_ok = 0;
    int timeouts_seen = 0;
    int send_hold = 0;
    int ready_hold = 0;
    int stall_cycles = 0;
    bit tail_steady = 1'b0;
    bit hold_request = 1'b0;
    bit long_hold_done = 1'b0;

    // parser image
    int unsigned frame_pos = 0;
    logic [7:0] fsum_a = 8'd0;
    logic [7:0] fsum_b = 8'd0;
    logic [7:0] msg_class = 8'd0;
    logic [7:0] msg_id = 8'd0;
    logic [15:0] msg_len = 16'd0;
    logic [7:0] got_ck_a = 8'd0;
    logic [7:0] stage_valid = 8'd0;
    logic [55:0] stage_dt = 56'd0;
    logic [31:0] stage_num[5] = '{default: 32'd0};
    logic [15:0] stage_fix_sv = 16'd0;
    logic [55:0] held_dt = 56'd0;
    logic [31:0] held_num[5] = '{default: 32'd0};
    logic [15:0] held_fix_sv = 16'd0;
    logic rx_active = 1'b0;
    logic [15:0] idle_ms = 16'd0;
    logic [15:0] timeout_ms = TIMEOUT_RESET;

    task automatic parse_step(input logic act, input logic [7:0] b);
        pvt_report_t rpt;
        int unsigned off;
        int unsigned slot;
        int unsigned base;
        rpt.accepted = 1'b0;
        rpt.time_upd = 1'b0;
        if (!act)
        begin
            if (frame_pos == POS_SYNC_FIRST)
            begin
                if (b == SYNC_FIRST)
                    frame_pos = POS_SYNC_SECOND;
            end
            else if (frame_pos == POS_SYNC_SECOND)
                frame_pos = (b == SYNC_SECOND) ? POS_CLASS : POS_SYNC_FIRST;
            else if (frame_pos == POS_CLASS)
            begin
                msg_class = b;
                fsum_a = b;
                fsum_b = b;
                frame_pos = POS_ID;
            end
            else if (frame_pos < POS_PAYLOAD)
            begin
                fsum_a = fsum_a + b;
                fsum_b = fsum_b + fsum_a;
                if (frame_pos == POS_ID)
                begin
                    msg_id = b;
                    frame_pos = POS_LEN_LO;
                end
                else if (frame_pos == POS_LEN_LO)
                begin
                    msg_len = {8'h00, b};
                    frame_pos = POS_LEN_HI;
                end
                else
                begin
                    msg_len[15:8] = b;
                    frame_pos = (FRAME_OVERHEAD + msg_len > FRAME_CAP) ? POS_SYNC_FIRST
                                                                       : POS_PAYLOAD;
                end
            end
            else
            begin
                off = frame_pos - POS_PAYLOAD;
                if (off < msg_len)
                begin
                    fsum_a = fsum_a + b;
                    fsum_b = fsum_b + fsum_a;
                    slot = 5;
                    base = 0;
                    case (off)
                        OFF_YEAR_LO: stage_dt[47:40] = b;
                        OFF_YEAR_HI: stage_dt[55:48] = b;
                        OFF_MONTH:   stage_dt[39:32] = b;
                        OFF_DAY:     stage_dt[31:24] = b;
                        OFF_HOUR:    stage_dt[23:16] = b;
                        OFF_MINUTE:  stage_dt[15:8] = b;
                        OFF_SECOND:  stage_dt[7:0] = b;
                        OFF_VALID:   stage_valid = b;
                        OFF_FIX:     stage_fix_sv[7:0] = b;
                        OFF_NUM_SV:  stage_fix_sv[15:8] = b;
                        default:
                        begin
                            if (off >= OFF_NANO_LO && off <= OFF_NANO_HI)
                            begin
                                slot = 0;
                                base = OFF_NANO_LO;
                            end
                            else if (off >= OFF_LON_LO && off <= OFF_HGT_HI)
                            begin
                                slot = 1 + (off - OFF_LON_LO) / 4;
                                base = OFF_LON_LO + 4 * (slot - 1);
                            end
                            else if (off >= OFF_SPEED_LO && off <= OFF_SPEED_HI)
                            begin
                                slot = 4;
                                base = OFF_SPEED_LO;
                            end
                        end
                    endcase
                    if (slot < 5)
                        stage_num[slot][8 * (off - base) +: 8] = b;
                    frame_pos = frame_pos + 1;
                end
                else if (off == msg_len)
                begin
                    got_ck_a = b;
                    frame_pos = frame_pos + 1;
                end
                else
                begin
                    if (got_ck_a == fsum_a && b == fsum_b && msg_class == PVT_CLASS &&
                        msg_id == PVT_ID && msg_len == PVT_LENGTH)
                    begin
                        rpt.accepted = 1'b1;
                        frames_ok++;
                        if ((stage_valid & DATE_TIME_BITS) == DATE_TIME_BITS)
                        begin
                            held_dt = stage_dt;
                            rpt.time_upd = 1'b1;
                            time_ok++;
                        end
                        held_num = stage_num;
                        if (stage_num[4][31])
                            held_num[4] = 32'd0;
                        held_fix_sv = stage_fix_sv;
                        rx_active = 1'b1;
                        idle_ms = 16'd0;
                    end
                    frame_pos = POS_SYNC_FIRST;
                end
            end
        end
        else if (idle_ms != IDLE_MAX)
            idle_ms = idle_ms + 16'd1;
        if (rx_active && idle_ms > timeout_ms)
        begin
            rx_active = 1'b0;
            timeouts_seen++;
        end
        rpt.utc = held_dt;
        rpt.nano = held_num[0];
        rpt.fix = held_fix_sv[7:0];
        rpt.sats = held_fix_sv[15:8];
        rpt.lon = held_num[1];
        rpt.lat = held_num[2];
        rpt.hgt = held_num[3];
        rpt.speed = held_num[4][30:0];
        rpt.active = rx_active;
        pvt_report_q.push_back(rpt);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= 1'b0;
            rx_byte <= 8'd0;
            send_hold = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_step(action, rx_byte);
                items_taken++;
            end
            if (in_valid && !in_ready)
                ;
            else if (send_hold != 0)
            begin
                send_hold--;
                in_valid <= 1'b0;
            end
            else if (rx_stream_q.size() != 0 && !tail_steady && $urandom_range(0, 99) < 6)
            begin
                send_hold = $urandom_range(0, 17);
                in_valid <= 1'b0;
            end
            else if (rx_stream_q.size() != 0)
            begin
                action <= rx_stream_q[0].act;
                rx_byte <= rx_stream_q[0].data;
                in_valid <= 1'b1;
                void'(rx_stream_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pvt_report_q.size() == 0)
                    report_mismatch("unexpected result transfer", 64'd0, 64'd0);
                else
                begin
                    head_rpt = pvt_report_q[0];
                    if (frame_accepted !== head_rpt.accepted)
                        report_mismatch("frame_accepted", 64'(frame_accepted),
                                        64'(head_rpt.accepted));
                    if (time_updated !== head_rpt.time_upd)
                        report_mismatch("time_updated", 64'(time_updated),
                                        64'(head_rpt.time_upd));
                    if (utc_date_time !== head_rpt.utc)
                        report_mismatch("utc_date_time", 64'(utc_date_time),
                                        64'(head_rpt.utc));
                    if (sub_second_ns !== head_rpt.nano)
                        report_mismatch("sub_second_ns", 64'(sub_second_ns),
                                        64'(head_rpt.nano));
                    if (fix_type !== head_rpt.fix)
                        report_mismatch("fix_type", 64'(fix_type), 64'(head_rpt.fix));
                    if (satellites !== head_rpt.sats)
                        report_mismatch("satellites", 64'(satellites), 64'(head_rpt.sats));
                    if (longitude !== head_rpt.lon)
                        report_mismatch("longitude", 64'(longitude), 64'(head_rpt.lon));
                    if (latitude !== head_rpt.lat)
                        report_mismatch("latitude", 64'(latitude), 64'(head_rpt.lat));
                    if (height_mm !== head_rpt.hgt)
                        report_mismatch("height_mm", 64'(height_mm), 64'(head_rpt.hgt));
                    if (ground_speed !== head_rpt.speed)
                        report_mismatch("ground_speed", 64'(ground_speed),
                                        64'(head_rpt.speed));
                    if (receiver_active !== head_rpt.active)
                        report_mismatch("receiver_active", 64'(receiver_active),
                                        64'(head_rpt.active));
                    void'(pvt_report_q.pop_front());
                end
            end
            if (ready_hold != 0)
            begin
                ready_hold--;
                out_ready <= 1'b0;
            end
            else if (hold_request && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                ready_hold = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (!tail_steady && $urandom_range(0, 99) < 7)
            begin
                ready_hold = $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("[%0t] no transfer for %0d cycles", $realtime, stall_cycles);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    task automatic queue_item(input logic act, input logic [7:0] b);
        rx_item_t item;
        item.act = act;
        item.data = b;
        rx_stream_q.push_back(item);
        items_queued++;
    endtask

    task automatic fill_body(input int mode);
        for (int i = 0; i < 128; i++)
            frame_body[i] = (mode == 1) ? 8'h00 : (mode == 2) ? 8'hFF
                                                              : 8'($urandom_range(0, 255));
    endtask

    // ck_err: 1 corrupts the first check byte, 2 the second; cut < 0 sends the whole frame
    task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len, input int body_len, input int ck_err,
                               input int cut, input int tick_pct);
        logic [7:0] seq[$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        int last;
        ck_a = 8'd0;
        ck_b = 8'd0;
        seq = '{SYNC_FIRST, SYNC_SECOND, cls, id, len[7:0], len[15:8]};
        for (int i = 0; i < body_len; i++)
            seq.push_back(frame_body[i]);
        for (int i = 2; i < seq.size(); i++)
        begin
            ck_a = ck_a + seq[i];
            ck_b = ck_b + ck_a;
        end
        seq.push_back(ck_err == 1 ? ~ck_a : ck_a);
        seq.push_back(ck_err == 2 ? ck_b ^ 8'h01 : ck_b);
        last = (cut < 0 || cut > seq.size()) ? seq.size() : cut;
        for (int i = 0; i < last; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                queue_item(1'b1, 8'($urandom_range(0, 255)));
            queue_item(1'b0, seq[i]);
        end
    endtask

    task automatic queue_pvt(input int mode, input logic [7:0] valid_bits, input int ck_err,
                             input int cut, input int tick_pct);
        fill_body(mode);
        frame_body[OFF_VALID] = valid_bits;
        queue_frame(PVT_CLASS, PVT_ID, PVT_LENGTH, PVT_LENGTH, ck_err, cut, tick_pct);
    endtask

    task automatic queue_traffic(input int n, input int tick_max);
        int target;
        int pick;
        int len;
        logic [7:0] vbits;
        target = items_queued + n;
        while (items_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                vbits = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) < 6)
                    vbits[1:0] = 2'b11;
                queue_pvt($urandom_range(0, 19) == 0 ? $urandom_range(1, 2) : 0, vbits,
                          $urandom_range(0, 99) < 15 ? $urandom_range(1, 2) : 0, -1, 3);
            end
            else if (pick < 62)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120)
                                                  : $urandom_range(0, 24);
                fill_body(0);
                if ($urandom_range(0, 3) == 0)
                    queue_frame(PVT_CLASS, PVT_ID, 16'(len), len, 0, -1, 3);
                else
                    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                16'(len), len, $urandom_range(0, 2), -1, 3);
            end
            else if (pick < 68)
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(FRAME_CAP - FRAME_OVERHEAD + 1, 65535)),
                            0, 0, 6, 0);
            else if (pick < 78)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    pick = $urandom_range(0, 9);
                    queue_item(1'b0, pick < 3 ? SYNC_FIRST : pick < 4 ? SYNC_SECOND
                                                           : 8'($urandom_range(0, 255)));
                end
            end
            else if (pick < 90)
                repeat ($urandom_range(1, tick_max))
                    queue_item(1'b1, 8'($urandom_range(0, 255)));
            else
                queue_pvt(0, 8'hFF, 0, $urandom_range(1, 99), 3);
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (items_taken != items_queued || results_checked != items_taken);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        timeout_ticks <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_ms = value;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timeout in force; sync, checksum, length and validity corner cases
        queue_item(1'b0, SYNC_FIRST);
        queue_item(1'b0, SYNC_FIRST);
        queue_item(1'b0, SYNC_SECOND);
        queue_pvt(0, DATE_TIME_BITS, 0, -1, 0);
        queue_pvt(2, 8'hFF, 0, -1, 0);
        queue_pvt(1, 8'h00, 0, -1, 0);
        queue_pvt(0, 8'h01, 0, -1, 0);
        queue_pvt(0, 8'h03, 1, -1, 0);
        queue_pvt(0, 8'h03, 2, -1, 0);
        fill_body(0);
        queue_frame(8'h02, PVT_ID, PVT_LENGTH, PVT_LENGTH, 0, -1, 0);
        queue_frame(PVT_CLASS, PVT_ID, PVT_LENGTH - 16'd1, PVT_LENGTH - 1, 0, -1, 0);
        queue_frame(PVT_CLASS, PVT_ID, 16'hFFFF, 0, 0, 6, 0);
        queue_frame(PVT_CLASS, PVT_ID, 16'(FRAME_CAP - FRAME_OVERHEAD + 1), 0, 0, 6, 0);
        queue_frame(8'h0A, 8'h04, 16'(FRAME_CAP - FRAME_OVERHEAD), FRAME_CAP - FRAME_OVERHEAD,
                    0, -1, 0);
        queue_frame(8'h06, 8'h01, 16'd0, 0, 0, -1, 0);
        repeat (5) queue_item(1'b1, 8'($urandom_range(0, 255)));
        drain();

        write_timeout(16'd0);
        queue_traffic(120, 6);
        drain();

        write_timeout(16'd25);
        hold_request = 1'b1;
        queue_traffic(220, 60);
        drain();

        // hold the longest timeout across a tick run, then lower it
        write_timeout(16'hFFFF);
        queue_pvt(0, DATE_TIME_BITS, 0, -1, 0);
        repeat (30) queue_item(1'b1, 8'($urandom_range(0, 255)));
        drain();

        write_timeout(16'd1000);
        queue_item(1'b1, 8'h00);
        queue_item(1'b0, 8'h00);
        queue_traffic(100, 40);
        drain();

        write_timeout(TIMEOUT_RESET);
        queue_traffic(120, 40);
        drain();

        tail_steady = 1'b1;
        queue_traffic(80, 20);
        drain();

        $display("Run covered %0d byte and tick transfers with timeouts 0, 25, 1000, 3000, 65535",
                 items_taken);
        $display("NAV-PVT frames accepted: %0d (%0d with UTC update), activity timeouts: %0d",
                 frames_ok, time_ok, timeouts_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
